@@ rtl/dnsa_pkg.sv @@
// Package for the DNS A-record response parser.
// Holds the beat types, the parse phase enum, status codes and constants.
// No dependencies.
package dnsa_pkg;

   localparam int POS_W = 10;
   localparam int MAX_PACKET_BYTES_DEF = 512;
   localparam int RSP_FIFO_DEPTH = 4;

   localparam logic [POS_W-1:0] HDR_LAST = POS_W'(11);
   localparam logic [POS_W-1:0] HDR_KEPT = POS_W'(8);
   localparam logic [3:0] QFIXED_LEN = 4'd4;
   localparam logic [3:0] RR_FIXED_LEN = 4'd10;
   localparam logic [3:0] RR_TC_LEN = 4'd4;
   localparam logic [3:0] RR_RDLEN_POS = 4'd8;
   localparam logic [1:0] PTR_MARK = 2'b11;
   localparam logic [1:0] LABEL_MARK = 2'b00;
   localparam logic [31:0] A_IN_TAG = 32'h0001_0001;
   localparam logic [15:0] A_RDLENGTH = 16'd4;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_TOO_SHORT = 3'd1;
   localparam logic [2:0] ST_ID_MISMATCH = 3'd2;
   localparam logic [2:0] ST_NOT_RESPONSE = 3'd3;
   localparam logic [2:0] ST_RCODE_ERROR = 3'd4;
   localparam logic [2:0] ST_BAD_QUESTION = 3'd5;

   typedef enum logic [3:0] {
      PH_HEADER = 4'd0,
      PH_QNAME  = 4'd1,
      PH_QPTR   = 4'd2,
      PH_QFIXED = 4'd3,
      PH_ANAME  = 4'd4,
      PH_APTR   = 4'd5,
      PH_AFIXED = 4'd6,
      PH_RDATA  = 4'd7,
      PH_DONE   = 4'd8
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_packet;
   } req_type;

   typedef struct packed {
      logic        is_summary;
      logic [31:0] ipv4_address;
      logic [2:0]  parse_status;
      logic [15:0] address_count;
      logic        last_of_run;
   } rsp_type;

endpackage

@@ rtl/dns_a_record_response_parser.sv @@
// DNS A-record response parser: one response byte per cycle, results through a
// four-entry queue. Depends on dnsa_pkg, dnsa_parse_core and dnsa_rsp_fifo.
//
// Accepts one packet byte per cycle; each byte is parsed in the cycle it is
// accepted and its results (an address, an end-of-packet summary, or both)
// enter a four-entry result queue. req_ready is high while the queue has room
// for two results, so the input rate is one byte per cycle as long as the
// result side keeps up. Bytes beyond MAX_PACKET_BYTES are ignored except for
// the end mark. The query ID is written through csr_wr_en/csr_wr_data; the
// user must write it only while idle; the block does not enforce this.
module dns_a_record_response_parser #(
   parameter int MAX_PACKET_BYTES = dnsa_pkg::MAX_PACKET_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dnsa_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dnsa_pkg::rsp_type rsp_payload,
   input  logic             csr_wr_en,
   input  logic [15:0]      csr_wr_data
);
   import dnsa_pkg::*;

   logic [15:0] qid_ff;
   logic        step;
   logic        push0, push1;
   rsp_type     data0, data1;
   logic        room2;

   assign req_ready = room2;
   assign step      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         qid_ff <= '0;
      end else if (csr_wr_en) begin
         qid_ff <= csr_wr_data;
      end
   end

   dnsa_parse_core #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .beat     (req_payload),
      .match_id (qid_ff),
      .push0    (push0),
      .push1    (push1),
      .data0    (data0),
      .data1    (data1)
   );

   dnsa_rsp_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push0       (push0),
      .push1       (push1),
      .data0       (data0),
      .data1       (data1),
      .room2       (room2),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ rtl/dnsa_rsp_fifo.sv @@
// Four-entry result queue; takes up to two results per cycle, gives one.
// Depends on dnsa_pkg.
module dnsa_rsp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push0,
   input  logic             push1,
   input  dnsa_pkg::rsp_type data0,
   input  dnsa_pkg::rsp_type data1,
   output logic             room2,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dnsa_pkg::rsp_type rsp_payload
);
   import dnsa_pkg::*;

   localparam int PTR_W = $clog2(RSP_FIFO_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   rsp_type           mem_ff [RSP_FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              pop;
   logic [CNT_W-1:0]  push_n;
   logic [PTR_W-1:0]  wr_ptr_nx;

   assign pop       = rsp_valid && rsp_ready;
   assign push_n    = CNT_W'(push0) + CNT_W'(push1);
   assign wr_ptr_nx = wr_ptr_ff + PTR_W'(1);
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + push_n - CNT_W'(pop);

   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = mem_ff[rd_ptr_ff];
   assign room2       = (count_ff <= CNT_W'(RSP_FIFO_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         mem_ff[wr_ptr_ff] <= data0;
      end
      if (push1) begin
         mem_ff[wr_ptr_nx] <= data1;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push0 || push1) |-> (count_ff + push_n <= CNT_W'(RSP_FIFO_DEPTH)))
      else $error("result queue overflow");

   a_push_order: assert property (@(posedge clock) disable iff (reset)
      push1 |-> push0)
      else $error("second push without first");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (!push0 && !pop) |=> $stable(count_ff))
      else $error("count moved without push or pop");

endmodule

@@ rtl/dnsa_parse_core.sv @@
// Byte-wise DNS response parse state and the results one byte produces.
// Depends on dnsa_pkg.
module dnsa_parse_core #(
   parameter int MAX_PACKET_BYTES = dnsa_pkg::MAX_PACKET_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  dnsa_pkg::req_type beat,
   input  logic [15:0]      match_id,
   output logic             push0,
   output logic             push1,
   output dnsa_pkg::rsp_type data0,
   output dnsa_pkg::rsp_type data1
);
   import dnsa_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in, pos_c;
   logic [63:0]      hdr_ff, hdr_in, hdr_c;
   logic [15:0]      qleft_ff, qleft_in, qleft_c;
   logic [15:0]      aleft_ff, aleft_in, aleft_c;
   phase_type        phase_ff, phase_in, phase_c;
   logic [5:0]       label_ff, label_in, label_c;
   logic [3:0]       fidx_ff, fidx_in, fidx_c;
   logic [31:0]      tc_ff, tc_in, tc_c;
   logic [15:0]      rdleft_ff, rdleft_in, rdleft_c;
   logic [31:0]      acc_ff, acc_in, acc_c;
   logic [15:0]      found_ff, found_in, found_c;
   logic [2:0]       err_ff, err_in, err_c;
   logic             emit_addr;
   logic [2:0]       status;

   logic [7:0]  b;
   logic [15:0] aleft_dec, qleft_dec, rd_new;
   logic [3:0]  fidx_inc;
   logic [31:0] acc_new;

   assign b         = beat.data_byte;
   assign aleft_dec = aleft_ff - 16'd1;
   assign qleft_dec = qleft_ff - 16'd1;
   assign fidx_inc  = fidx_ff + 4'd1;
   assign rd_new    = (fidx_ff >= RR_RDLEN_POS) ? {rdleft_ff[7:0], b} : rdleft_ff;
   assign acc_new   = {acc_ff[23:0], b};

   // next state for one parsed byte
   always_comb begin
      pos_c     = pos_ff;
      hdr_c     = hdr_ff;
      qleft_c   = qleft_ff;
      aleft_c   = aleft_ff;
      phase_c   = phase_ff;
      label_c   = label_ff;
      fidx_c    = fidx_ff;
      tc_c      = tc_ff;
      rdleft_c  = rdleft_ff;
      acc_c     = acc_ff;
      found_c   = found_ff;
      err_c     = err_ff;
      emit_addr = 1'b0;
      if (pos_ff < POS_W'(MAX_PACKET_BYTES)) begin
         pos_c = pos_ff + POS_W'(1);
         unique case (phase_ff)
            PH_HEADER: begin
               if (pos_ff < HDR_KEPT) begin
                  hdr_c = {hdr_ff[55:0], b};
               end
               if (pos_ff == HDR_LAST) begin
                  phase_c = PH_DONE;
                  if (hdr_ff[63:48] != match_id) begin
                     err_c = ST_ID_MISMATCH;
                  end else if (!hdr_ff[47]) begin
                     err_c = ST_NOT_RESPONSE;
                  end else if (hdr_ff[35:32] != 4'd0) begin
                     err_c = ST_RCODE_ERROR;
                  end else if (hdr_ff[15:0] != 16'd0) begin
                     qleft_c = hdr_ff[31:16];
                     aleft_c = hdr_ff[15:0];
                     label_c = '0;
                     phase_c = (hdr_ff[31:16] != 16'd0) ? PH_QNAME : PH_ANAME;
                  end
               end
            end
            PH_QNAME, PH_ANAME: begin
               if (label_ff != '0) begin
                  label_c = label_ff - 6'd1;
               end else if (b == 8'd0) begin
                  fidx_c   = '0;
                  tc_c     = '0;
                  rdleft_c = '0;
                  phase_c  = (phase_ff == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
               end else if (b[7:6] == PTR_MARK) begin
                  phase_c = (phase_ff == PH_QNAME) ? PH_QPTR : PH_APTR;
               end else if (b[7:6] == LABEL_MARK) begin
                  label_c = b[5:0];
               end else begin
                  if (phase_ff == PH_QNAME) begin
                     err_c = ST_BAD_QUESTION;
                  end
                  phase_c = PH_DONE;
               end
            end
            PH_QPTR: begin
               fidx_c  = '0;
               phase_c = PH_QFIXED;
            end
            PH_APTR: begin
               fidx_c   = '0;
               tc_c     = '0;
               rdleft_c = '0;
               phase_c  = PH_AFIXED;
            end
            PH_QFIXED: begin
               fidx_c = fidx_inc;
               if (fidx_inc == QFIXED_LEN) begin
                  qleft_c = qleft_dec;
                  label_c = '0;
                  phase_c = (qleft_dec == 16'd0) ? PH_ANAME : PH_QNAME;
               end
            end
            PH_AFIXED: begin
               if (fidx_ff < RR_TC_LEN) begin
                  tc_c = {tc_ff[23:0], b};
               end
               rdleft_c = rd_new;
               fidx_c   = fidx_inc;
               if (fidx_inc == RR_FIXED_LEN) begin
                  if (rd_new != A_RDLENGTH) begin
                     tc_c = '0;
                  end
                  acc_c = '0;
                  if (rd_new == 16'd0) begin
                     aleft_c = aleft_dec;
                     label_c = '0;
                     phase_c = (aleft_dec == 16'd0) ? PH_DONE : PH_ANAME;
                  end else begin
                     phase_c = PH_RDATA;
                  end
               end
            end
            PH_RDATA: begin
               acc_c    = acc_new;
               rdleft_c = rdleft_ff - 16'd1;
               if (rdleft_ff == 16'd1) begin
                  if (tc_ff == A_IN_TAG) begin
                     found_c   = found_ff + 16'd1;
                     emit_addr = 1'b1;
                  end
                  aleft_c = aleft_dec;
                  label_c = '0;
                  phase_c = (aleft_dec == 16'd0) ? PH_DONE : PH_ANAME;
               end
            end
            PH_DONE: begin
            end
            default: begin
               phase_c = PH_DONE;
            end
         endcase
      end
   end

   always_comb begin
      if (phase_c == PH_HEADER) begin
         status = ST_TOO_SHORT;
      end else if (err_c != ST_OK) begin
         status = err_c;
      end else if (phase_c == PH_QNAME || phase_c == PH_QPTR || phase_c == PH_QFIXED) begin
         status = ST_BAD_QUESTION;
      end else begin
         status = ST_OK;
      end
   end

   // clear per-packet state after the end mark
   always_comb begin
      if (beat.end_of_packet) begin
         pos_in    = '0;
         hdr_in    = '0;
         qleft_in  = '0;
         aleft_in  = '0;
         phase_in  = PH_HEADER;
         label_in  = '0;
         fidx_in   = '0;
         tc_in     = '0;
         rdleft_in = '0;
         acc_in    = '0;
         found_in  = '0;
         err_in    = ST_OK;
      end else begin
         pos_in    = pos_c;
         hdr_in    = hdr_c;
         qleft_in  = qleft_c;
         aleft_in  = aleft_c;
         phase_in  = phase_c;
         label_in  = label_c;
         fidx_in   = fidx_c;
         tc_in     = tc_c;
         rdleft_in = rdleft_c;
         acc_in    = acc_c;
         found_in  = found_c;
         err_in    = err_c;
      end
   end

   // result beats for this byte
   always_comb begin
      rsp_type addr_r;
      rsp_type sum_r;
      addr_r.is_summary    = 1'b0;
      addr_r.ipv4_address  = acc_new;
      addr_r.parse_status  = ST_OK;
      addr_r.address_count = found_c;
      addr_r.last_of_run   = !beat.end_of_packet;
      sum_r.is_summary     = 1'b1;
      sum_r.ipv4_address   = '0;
      sum_r.parse_status   = status;
      sum_r.address_count  = found_c;
      sum_r.last_of_run    = 1'b1;
      push0 = step && (emit_addr || beat.end_of_packet);
      push1 = step && emit_addr && beat.end_of_packet;
      data0 = emit_addr ? addr_r : sum_r;
      data1 = sum_r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         hdr_ff    <= '0;
         qleft_ff  <= '0;
         aleft_ff  <= '0;
         phase_ff  <= PH_HEADER;
         label_ff  <= '0;
         fidx_ff   <= '0;
         tc_ff     <= '0;
         rdleft_ff <= '0;
         acc_ff    <= '0;
         found_ff  <= '0;
         err_ff    <= ST_OK;
      end else if (step) begin
         pos_ff    <= pos_in;
         hdr_ff    <= hdr_in;
         qleft_ff  <= qleft_in;
         aleft_ff  <= aleft_in;
         phase_ff  <= phase_in;
         label_ff  <= label_in;
         fidx_ff   <= fidx_in;
         tc_ff     <= tc_in;
         rdleft_ff <= rdleft_in;
         acc_ff    <= acc_in;
         found_ff  <= found_in;
         err_ff    <= err_in;
      end
   end

endmodule
